FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge
`define ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/fpst_pkg.sv
`default_nettype none
package fpst_pkg;

  localparam int SIZE_DEF = 1024;
  // wide enough for a node number at the largest supported size
  localparam int POS_W    = 17;
  localparam int QDEPTH   = 4;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_PREFIX = 2'd1;
  localparam logic [1:0] CMD_RANGE  = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_PREFIX,
    OP_RANGE
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  hi_k;
    logic [POS_W-1:0]  lo_k;
    logic signed [31:0] delta;
  } job_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

endpackage
`default_nettype wire

FILE: rtl/fpst_ram.sv
`default_nettype none
module fpst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/fpst_front.sv
`default_nettype none
module fpst_front #(
  parameter int SIZE = fpst_pkg::SIZE_DEF
) (
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [55:0]         s_axis_tdata,
  input  wire logic [1:0]          s_axis_tuser,
  input  wire fpst_pkg::back_stat_t stat,
  input  wire logic                q_ready,
  output logic                     q_push,
  output fpst_pkg::job_t           q_job
);

  logic [31:0] idx32;
  logic [31:0] lo32;
  logic        hi_in;
  logic        lo_in;
  logic [31:0] hi_pos;
  logic [31:0] lo_pos;
  logic        keep;

  assign idx32 = {22'd0, s_axis_tdata[9:0]};
  assign lo32  = {22'd0, s_axis_tdata[19:10]};
  assign hi_in = idx32 < 32'(SIZE);
  assign lo_in = lo32 < 32'(SIZE);

  // query ends saturate at the last position
  assign hi_pos = hi_in ? idx32 : 32'(SIZE - 1);
  assign lo_pos = lo_in ? lo32 : 32'(SIZE - 1);

  always_comb begin
    keep        = 1'b0;
    q_job.op    = fpst_pkg::OP_PREFIX;
    q_job.hi_k  = fpst_pkg::POS_W'(hi_pos + 32'd1);
    q_job.lo_k  = fpst_pkg::POS_W'(lo_pos);
    q_job.delta = s_axis_tdata[51:20];
    case (s_axis_tuser)
      fpst_pkg::CMD_ADD: begin
        keep     = hi_in;
        q_job.op = fpst_pkg::OP_ADD;
      end
      fpst_pkg::CMD_PREFIX: begin
        keep     = 1'b1;
        q_job.op = fpst_pkg::OP_PREFIX;
      end
      fpst_pkg::CMD_RANGE: begin
        keep     = 1'b1;
        q_job.op = fpst_pkg::OP_RANGE;
      end
      default: begin
        keep     = 1'b0;
        q_job.op = fpst_pkg::OP_PREFIX;
      end
    endcase
  end

  // dropped beats are still taken, they just never reach the queue
  assign s_axis_tready = q_ready & ~stat.clearing;
  assign q_push        = s_axis_tvalid & s_axis_tready & keep;

endmodule
`default_nettype wire

FILE: rtl/fpst_fifo.sv
`default_nettype none
module fpst_fifo #(
  parameter int DEPTH = fpst_pkg::QDEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire fpst_pkg::job_t push_job,
  output logic                in_ready,
  input  wire logic           pop,
  output fpst_pkg::job_t      pop_job,
  output logic                out_valid
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  fpst_pkg::job_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign in_ready  = count != CW'(DEPTH);
  assign out_valid = count != '0;
  assign do_push   = push & in_ready;
  assign do_pop    = pop & out_valid;
  assign pop_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/fpst_back.sv
`default_nettype none
module fpst_back #(
  parameter int SIZE = fpst_pkg::SIZE_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire fpst_pkg::job_t q_job,
  output logic                q_pop,
  output fpst_pkg::back_stat_t stat,
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [63:0]         m_axis_tdata
);

  localparam int AW = $clog2(SIZE);
  localparam int KW = $clog2(SIZE + 1);
  localparam int KN = KW + 1;

  fpst_pkg::state_t state;
  fpst_pkg::state_t state_next;

  fpst_pkg::op_t      op;
  logic [KN-1:0]      k;
  logic [KN-1:0]      lo_k;
  logic               phase_lo;
  logic signed [31:0] delta;
  logic [63:0]        acc;
  logic               pend;
  logic               pend_neg;
  logic [AW-1:0]      pend_addr;
  logic [AW-1:0]      clr_addr;

  logic [KN-1:0]      low_bit;
  logic               live;
  logic               switch_lo;
  logic               walk_done;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [63:0]        ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [63:0]        ram_rdata;

  assign low_bit   = k & (~k + KN'(1));
  assign live      = (op == fpst_pkg::OP_ADD) ? (k <= KN'(SIZE)) : (k != '0);
  assign switch_lo = !live && op == fpst_pkg::OP_RANGE && !phase_lo;
  assign walk_done = !live && !switch_lo && !pend;

  assign ram_raddr = AW'(k - KN'(1));
  assign ram_we    = (state == fpst_pkg::ST_CLEAR) || (pend && op == fpst_pkg::OP_ADD);
  assign ram_waddr = (state == fpst_pkg::ST_CLEAR) ? clr_addr : pend_addr;
  assign ram_wdata = (state == fpst_pkg::ST_CLEAR) ? 64'd0
                   : ram_rdata + {{32{delta[31]}}, delta};

  fpst_ram #(
    .WIDTH(64),
    .DEPTH(SIZE)
  ) u_nodes (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      fpst_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(SIZE - 1)) begin
          state_next = fpst_pkg::ST_IDLE;
        end
      end
      fpst_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = fpst_pkg::ST_WALK;
        end
      end
      fpst_pkg::ST_WALK: begin
        if (walk_done) begin
          state_next = (op == fpst_pkg::OP_ADD) ? fpst_pkg::ST_IDLE : fpst_pkg::ST_OUT;
        end
      end
      fpst_pkg::ST_OUT: begin
        if (m_axis_tready) begin
          state_next = fpst_pkg::ST_IDLE;
        end
      end
      default: state_next = fpst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    m_axis_tvalid = 1'b0;
    stat.clearing = 1'b0;
    stat.busy     = 1'b1;
    case (state)
      fpst_pkg::ST_CLEAR: stat.clearing = 1'b1;
      fpst_pkg::ST_IDLE: begin
        q_pop     = q_valid;
        stat.busy = 1'b0;
      end
      fpst_pkg::ST_WALK: stat.busy = 1'b1;
      fpst_pkg::ST_OUT:  m_axis_tvalid = 1'b1;
      default:           stat.busy = 1'b1;
    endcase
  end

  assign m_axis_tdata = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fpst_pkg::ST_CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == fpst_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      pend <= (state == fpst_pkg::ST_WALK) && live;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      fpst_pkg::ST_IDLE: begin
        op       <= q_job.op;
        k        <= KN'(q_job.hi_k);
        lo_k     <= KN'(q_job.lo_k);
        delta    <= q_job.delta;
        phase_lo <= 1'b0;
        acc      <= 64'd0;
      end
      fpst_pkg::ST_WALK: begin
        // node read in the previous cycle lands now; queries fold it into the sum
        if (pend && op != fpst_pkg::OP_ADD) begin
          acc <= pend_neg ? acc - ram_rdata : acc + ram_rdata;
        end
        if (live) begin
          pend_addr <= ram_raddr;
          pend_neg  <= phase_lo;
          k         <= (op == fpst_pkg::OP_ADD) ? k + low_bit : k - low_bit;
        end else if (switch_lo) begin
          k        <= lo_k;
          phase_lo <= 1'b1;
        end
      end
      default: begin
        phase_lo <= phase_lo;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/fenwick_prefix_sum_tree_top.sv
// binary indexed tree of 64-bit wrapping sums over SIZE positions. each input beat carries a
// command in tuser: point add (0), prefix sum (1) or range sum (2); command 3 and adds beyond the
// last position are taken and dropped, query ends past the last position saturate to it. queries
// return one result beat, adds return none. a front stage classifies beats into a four-entry
// queue and the back end walks the node memory, one node per cycle through its single read port
// with a read-modify-write pipeline for adds: a job walks the nodes on its chain (at most
// log2(SIZE)+1, twice that for a range sum), and a query waits in its result state until the
// result is taken. after reset the node memory is cleared one entry a cycle, with
// s_axis_tready held low.
`default_nettype none
`include "assert_macros.svh"
module fenwick_prefix_sum_tree_top #(
  parameter int SIZE = fpst_pkg::SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // index[9:0], low_index[19:10], delta[51:20], zero
  input  wire logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata   // total[63:0]
);

  fpst_pkg::back_stat_t stat;
  fpst_pkg::job_t       push_job;
  fpst_pkg::job_t       pop_job;
  logic                 q_push;
  logic                 q_ready;
  logic                 q_pop;
  logic                 q_valid;

  fpst_front #(
    .SIZE(SIZE)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .stat         (stat),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  fpst_fifo #(
    .DEPTH(fpst_pkg::QDEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .in_ready (q_ready),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .out_valid(q_valid)
  );

  fpst_back #(
    .SIZE(SIZE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_job        (pop_job),
    .q_pop        (q_pop),
    .stat         (stat),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  `ASSERT_RUN(a_no_take_in_clear, stat.clearing |-> !s_axis_tready, "beat taken during clear")
  `ASSERT_RUN(a_no_pop_with_result, m_axis_tvalid |-> !q_pop, "job popped while result pending")
  `ASSERT_RUN(a_pop_starts_job, q_pop |=> stat.busy, "popped job did not start")
  `ASSERT_ALL(a_clear_not_busy_idle, stat.clearing |-> stat.busy, "clear while idle")

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int SIZE = fpst_pkg::SIZE_DEF;
  localparam int CYCLE_LIMIT = 500_000;
  // cmd 3 is taken and dropped by the block
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;  // index[9:0], low_index[19:10], delta[51:20], zero
  logic [1:0]  s_axis_tuser = '0;  // cmd[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // total[63:0]

  logic [63:0] node_sums [1:SIZE];
  logic [63:0] pending_totals [$];
  logic [63:0] want_total;
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          send_steady = 1'b0;
  bit          recv_steady = 1'b0;

  fenwick_prefix_sum_tree_top #(.SIZE(SIZE)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[fenwick_prefix_sum_tree_top] ERROR");
      $finish;
    end
  end

  // tree model: node k holds the sum of the positions ending at k-1
  function automatic void tree_add(int unsigned pos, logic [63:0] amount);
    int unsigned k;
    k = pos + 1;
    while (k <= SIZE) begin
      node_sums[k] += amount;
      k += k & (~k + 1);
    end
  endfunction

  // sum of positions 0..count-1
  function automatic logic [63:0] tree_prefix(int unsigned count);
    logic [63:0] acc;
    int unsigned k;
    acc = '0;
    k = (count > SIZE) ? SIZE : count;
    while (k > 0) begin
      acc += node_sums[k];
      k -= k & (~k + 1);
    end
    return acc;
  endfunction

  function automatic int unsigned clamp_pos(int unsigned pos);
    return (pos >= SIZE) ? SIZE - 1 : pos;
  endfunction

  function automatic void tree_apply(logic [1:0] cmd, logic [9:0] idx, logic [9:0] lo,
                                     logic [31:0] delta);
    case (cmd)
      fpst_pkg::CMD_ADD: begin
        if (idx < SIZE) tree_add(idx, {{32{delta[31]}}, delta});
      end
      fpst_pkg::CMD_PREFIX: pending_totals.push_back(tree_prefix(clamp_pos(idx) + 1));
      fpst_pkg::CMD_RANGE: pending_totals.push_back(tree_prefix(clamp_pos(idx) + 1)
                                                    - tree_prefix(clamp_pos(lo)));
      default: ;
    endcase
  endfunction

  // result side: random stalls and the check against the oldest expected total
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= recv_steady || ($urandom_range(99) >= 20);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_totals.size() == 0) begin
          $error("total: expected none, got %h", m_axis_tdata);
          fail_count++;
        end else begin
          want_total = pending_totals.pop_front();
          if (m_axis_tdata !== want_total) begin
            $error("total: expected %h, got %h", want_total, m_axis_tdata);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic send_beat(logic [1:0] cmd, logic [9:0] idx, logic [9:0] lo,
                           logic [31:0] delta);
    int gap;
    if (!send_steady && $urandom_range(99) < 20) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 56'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, delta, lo, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tree_apply(cmd, idx, lo, delta);
  endtask

  // hold the sender off until every query has answered
  task automatic settle_results();
    s_axis_tvalid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
  endtask

  function automatic logic [9:0] pick_pos();
    case ($urandom_range(7))
      0: return 10'd0;
      1: return 10'(SIZE - 1);
      2: return 10'(1 << $urandom_range(9));
      3: return 10'((1 << $urandom_range(10)) - 1);
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_delta();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_cmd(int add_pct);
    int r;
    r = $urandom_range(99);
    if (r < add_pct) return fpst_pkg::CMD_ADD;
    if (r >= 97) return CMD_NONE;
    return ($urandom_range(1)) ? fpst_pkg::CMD_PREFIX : fpst_pkg::CMD_RANGE;
  endfunction

  task automatic test_directed();
    send_beat(fpst_pkg::CMD_ADD, 10'd0, 10'd0, 32'h7fff_ffff);
    send_beat(fpst_pkg::CMD_ADD, 10'd1023, 10'd0, 32'h8000_0000);
    send_beat(fpst_pkg::CMD_ADD, 10'd512, 10'd0, 32'hffff_ffff);
    send_beat(fpst_pkg::CMD_ADD, 10'd511, 10'd1023, 32'd1);
    send_beat(CMD_NONE, 10'd3, 10'd0, 32'd5);
    send_beat(CMD_NONE, 10'd1023, 10'd1023, 32'hffff_ffff);
    send_beat(fpst_pkg::CMD_PREFIX, 10'd0, 10'd0, 32'd0);
    send_beat(fpst_pkg::CMD_PREFIX, 10'd511, 10'd0, 32'd0);
    send_beat(fpst_pkg::CMD_PREFIX, 10'd512, 10'd0, 32'd0);
    send_beat(fpst_pkg::CMD_PREFIX, 10'd1023, 10'd1023, 32'hffff_ffff);
    send_beat(fpst_pkg::CMD_RANGE, 10'd0, 10'd0, 32'd0);
    send_beat(fpst_pkg::CMD_RANGE, 10'd1023, 10'd0, 32'd0);
    send_beat(fpst_pkg::CMD_RANGE, 10'd1023, 10'd1023, 32'd0);
    // reversed ranges give minus the sum strictly between the ends
    send_beat(fpst_pkg::CMD_RANGE, 10'd10, 10'd600, 32'd0);
    send_beat(fpst_pkg::CMD_RANGE, 10'd0, 10'd1, 32'd0);
    send_beat(fpst_pkg::CMD_RANGE, 10'd512, 10'd512, 32'd0);
    send_beat(fpst_pkg::CMD_ADD, 10'd0, 10'd0, 32'h7fff_ffff);
    send_beat(fpst_pkg::CMD_ADD, 10'd0, 10'd0, 32'h7fff_ffff);
    send_beat(fpst_pkg::CMD_PREFIX, 10'd0, 10'd0, 32'd0);
    send_beat(fpst_pkg::CMD_ADD, 10'd1023, 10'd0, 32'h8000_0000);
    send_beat(fpst_pkg::CMD_RANGE, 10'd1023, 10'd1, 32'd0);
    send_beat(fpst_pkg::CMD_PREFIX, 10'd1022, 10'd0, 32'd0);
    settle_results();
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_beat(pick_cmd(45), pick_pos(), pick_pos(), pick_delta());
    settle_results();
  endtask

  // all positions crowded into the sixteen at one end of the tree or the other
  task automatic test_narrow_window(int count);
    logic [9:0] base;
    repeat (count) begin
      base = $urandom_range(1) ? 10'd0 : 10'(SIZE - 16);
      send_beat(pick_cmd(50), base + 10'($urandom_range(15)), base + 10'($urandom_range(15)),
                pick_delta());
    end
    settle_results();
  endtask

  task automatic test_back_to_back(int count);
    send_steady = 1'b1;
    recv_steady = 1'b1;
    repeat (count) send_beat(pick_cmd(40), pick_pos(), pick_pos(), pick_delta());
    settle_results();
    send_steady = 1'b0;
    recv_steady = 1'b0;
  endtask

  initial begin
    for (int k = 1; k <= SIZE; k++) node_sums[k] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix(900);
    test_narrow_window(300);
    test_back_to_back(300);
    test_random_mix(80);
    settle_results();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("[fenwick_prefix_sum_tree_top] OK");
    end else begin
      $display("[fenwick_prefix_sum_tree_top] ERROR");
    end
    $finish;
  end

endmodule
